// ===== rtl/core/dsat_pkg.sv =====
// Package for the DSATUR coloring block: payload structs, sequencer states
// and shared constants. No dependencies.
package dsat_pkg;

	localparam int NODE_LIMIT_DEF  = 64;
	localparam int COLOR_LIMIT_DEF = 64;

	typedef struct packed {
		logic [5:0]  row_index;
		logic [63:0] row_bits;
		logic        last_row;
	} row_item_t;

	typedef struct packed {
		logic [5:0] node;
		logic [6:0] color;
		logic [6:0] color_count;
		logic       last;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DEGREE,
		ST_SCAN,
		ST_PICK,
		ST_EMIT
	} state_t;

endpackage

// ===== rtl/core/dsat_used_unit.sv =====
// Shared neighbour-color unit: one clocked pass over a node's row builds the
// set of colors used by colored neighbours. Depends on dsat_pkg.
module dsat_used_unit #(
	parameter int NODE_LIMIT  = dsat_pkg::NODE_LIMIT_DEF,
	parameter int COLOR_LIMIT = dsat_pkg::COLOR_LIMIT_DEF
) (
	input  logic                   clk,
	input  logic                   clr,
	input  logic                   en,
	input  logic                   adj_bit,
	input  logic                   nb_done,
	input  logic [6:0]             nb_color,
	output logic [COLOR_LIMIT-1:0] used
);
	import dsat_pkg::*;

	logic [COLOR_LIMIT-1:0] used_q;

	// Accumulate one neighbour per cycle while en is high
	always_ff @(posedge clk) begin
		if (clr) begin
			used_q <= '0;
		end else if (en && adj_bit && nb_done && (nb_color < 7'(COLOR_LIMIT))) begin
			used_q[nb_color[$clog2(COLOR_LIMIT)-1:0]] <= 1'b1;
		end
	end

	assign used = used_q;
endmodule

// ===== rtl/core/dsatur_graph_coloring.sv =====
// DSATUR graph coloring top level. Depends on dsat_pkg and dsat_used_unit.
// A row that is not last is stored and busy never rises.
// A last row runs V nodes, node_count held to 1..NODE_LIMIT: V degree
// passes, then V steps of V candidate passes plus one assign state each.
// Results follow in node order, one result per cycle; busy drops after
// the last. Reset sets node_count to 1.
module dsatur_graph_coloring #(
	parameter int NODE_LIMIT  = dsat_pkg::NODE_LIMIT_DEF,
	parameter int COLOR_LIMIT = dsat_pkg::COLOR_LIMIT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  dsat_pkg::row_item_t item,
	input  logic                cfg_we,
	input  logic [6:0]          cfg_data,
	output logic                result_valid,
	output dsat_pkg::result_t   result
);
	import dsat_pkg::*;

	localparam int NW = $clog2(NODE_LIMIT);

	logic [63:0] adj_mem [NODE_LIMIT];
	logic [6:0]  deg_q   [NODE_LIMIT];
	logic [6:0]  col_q   [NODE_LIMIT];
	logic [NODE_LIMIT-1:0] done_q;

	state_t      state_q, state_d;
	logic [6:0]  ncount_q;
	logic [6:0]  v_q;
	logic [6:0]  i_q;      // node of the current pass
	logic [6:0]  j_q;      // pass cycle: 0 loads the row, 1..v walk columns
	logic [6:0]  step_q;
	logic [NODE_LIMIT-1:0] row_q;
	logic [6:0]  best_sat_q, best_deg_q, cand_deg_q;
	logic [NW-1:0] best_q;
	logic [COLOR_LIMIT-1:0] best_used_q;
	logic        have_best_q;
	logic [6:0]  highest_q;
	logic [6:0]  degacc_q;

	// neighbour column pipeline
	logic        en_s1, adj_s1, done_s1;
	logic [6:0]  nbcol_s1;

	// result pipeline
	logic        res_valid_s1, res_last_s1;
	logic [5:0]  res_node_s1;
	logic [6:0]  res_color_s1;

	logic        accept;
	logic        uu_clr;
	logic        pass_end, last_node, col_issue;
	logic [COLOR_LIMIT-1:0] used;
	logic [6:0]  sat, chosen;
	logic [6:0]  v_eff;
	logic [6:0]  col_idx;

	assign accept = start && !busy;
	assign v_eff = (ncount_q == 7'd0) ? 7'd1 :
		(ncount_q > 7'(NODE_LIMIT)) ? 7'(NODE_LIMIT) : ncount_q;
	assign pass_end = (j_q == v_q + 7'd2);
	assign last_node = (i_q == v_q - 7'd1);
	assign col_issue = (j_q != 7'd0) && (j_q <= v_q);
	assign col_idx = j_q - 7'd1;

	dsat_used_unit #(.NODE_LIMIT(NODE_LIMIT), .COLOR_LIMIT(COLOR_LIMIT)) u_used (
		.clk(clk), .clr(uu_clr), .en(en_s1),
		.adj_bit(adj_s1),
		.nb_done(done_s1),
		.nb_color(nbcol_s1),
		.used(used)
	);

	// Saturation of the scanned node, smallest free color of the best node
	always_comb begin
		sat = 7'($countones(used));
		chosen = 7'(COLOR_LIMIT);
		for (int c = COLOR_LIMIT - 1; c >= 0; c--) begin
			if (!best_used_q[c]) chosen = 7'(c);
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (accept && item.last_row) state_d = ST_DEGREE;
			ST_DEGREE: if (pass_end && last_node) state_d = ST_SCAN;
			ST_SCAN:   if (pass_end && last_node) state_d = ST_PICK;
			ST_PICK:   state_d = (step_q == v_q - 7'd1) ? ST_EMIT : ST_SCAN;
			ST_EMIT:   if (i_q == v_q) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		busy = (state_q != ST_IDLE);
		uu_clr = (state_q == ST_SCAN) && (j_q == 7'd0);
		result_valid = res_valid_s1;
		result.node = res_node_s1;
		result.color = res_color_s1;
		result.color_count = highest_q + 7'd1;
		result.last = res_last_s1;
	end

	// Store rows, read tables into registers
	always_ff @(posedge clk) begin
		if (accept && (7'(item.row_index) < 7'(NODE_LIMIT))) begin
			adj_mem[item.row_index[NW-1:0]] <= item.row_bits;
		end
		if ((state_q == ST_DEGREE || state_q == ST_SCAN) && j_q == 7'd0) begin
			row_q <= adj_mem[i_q[NW-1:0]][NODE_LIMIT-1:0];
		end
		if (state_q == ST_DEGREE && pass_end) begin
			deg_q[i_q[NW-1:0]] <= degacc_q;
		end
		if (state_q == ST_SCAN && j_q == 7'd0) begin
			cand_deg_q <= deg_q[i_q[NW-1:0]];
		end
		if (state_q == ST_PICK) begin
			col_q[best_q] <= chosen;
		end
		adj_s1 <= row_q[col_idx[NW-1:0]];
		done_s1 <= done_q[col_idx[NW-1:0]];
		nbcol_s1 <= col_q[col_idx[NW-1:0]];
		res_node_s1 <= i_q[5:0];
		res_color_s1 <= col_q[i_q[NW-1:0]];
		res_last_s1 <= last_node;
		// Keep the best candidate when its pass completes
		if (state_q == ST_SCAN && pass_end && !done_q[i_q[NW-1:0]]) begin
			if (!have_best_q || sat > best_sat_q ||
				(sat == best_sat_q && cand_deg_q > best_deg_q)) begin
				best_q <= i_q[NW-1:0];
				best_sat_q <= sat;
				best_deg_q <= cand_deg_q;
				best_used_q <= used;
			end
		end
	end

	// Node register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ncount_q <= 7'd1;
		end else if (cfg_we) begin
			ncount_q <= cfg_data;
		end
	end

	// Sequencer datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			v_q <= 7'd1;
			done_q <= '0;
			highest_q <= '0;
			i_q <= '0;
			j_q <= '0;
			step_q <= '0;
			degacc_q <= '0;
			have_best_q <= 1'b0;
			en_s1 <= 1'b0;
			res_valid_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			en_s1 <= (state_q == ST_SCAN) && col_issue;
			res_valid_s1 <= (state_q == ST_EMIT) && (i_q < v_q);
			case (state_q)
				ST_IDLE: if (accept && item.last_row) begin
					v_q <= v_eff;
					i_q <= '0;
					j_q <= '0;
					done_q <= '0;
					highest_q <= '0;
					step_q <= '0;
					have_best_q <= 1'b0;
				end
				ST_DEGREE: begin
					// Count one column of row i per cycle
					if (j_q == 7'd0) begin
						degacc_q <= '0;
					end else if (col_issue && row_q[col_idx[NW-1:0]]) begin
						degacc_q <= degacc_q + 7'd1;
					end
					if (pass_end) begin
						j_q <= '0;
						i_q <= last_node ? 7'd0 : i_q + 7'd1;
					end else begin
						j_q <= j_q + 7'd1;
					end
				end
				ST_SCAN: begin
					if (pass_end) begin
						if (!done_q[i_q[NW-1:0]]) have_best_q <= 1'b1;
						j_q <= '0;
						i_q <= last_node ? 7'd0 : i_q + 7'd1;
					end else begin
						j_q <= j_q + 7'd1;
					end
				end
				ST_PICK: begin
					done_q[best_q] <= 1'b1;
					if (chosen > highest_q) highest_q <= chosen;
					step_q <= step_q + 7'd1;
					have_best_q <= 1'b0;
					i_q <= '0;
					j_q <= '0;
				end
				ST_EMIT: if (i_q != v_q) i_q <= i_q + 7'd1;
				default: ;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy) else $error("result while idle");
	a_color_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.color <= 7'(COLOR_LIMIT)) else $error("color range");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |=> !busy) else $error("no idle after last");
`endif
endmodule
